// ----- hw/rtl/aac_pkg.sv -----
`default_nettype none

package aac_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PER_W   = 16;
  localparam int unsigned WDOG_W  = 24;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [PER_W-1:0]  PER_MAX  = '1;
  localparam logic [WDOG_W-1:0] WDOG_MAX = '1;

  localparam logic [PER_W-1:0]  TOGGLE_PERIOD_RST  = 16'd500;
  localparam logic [PER_W-1:0]  POLL_PERIOD_RST    = 16'd200;
  localparam logic [WDOG_W-1:0] WATCHDOG_LIMIT_RST = 24'd15000;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_TOGGLE_PERIOD  = 2'd0;
  localparam logic [1:0] REG_POLL_PERIOD    = 2'd1;
  localparam logic [1:0] REG_WATCHDOG_LIMIT = 2'd2;

  localparam logic [1:0] LAMP_OFF    = 2'd0;
  localparam logic [1:0] LAMP_GREEN  = 2'd1;
  localparam logic [1:0] LAMP_YELLOW = 2'd2;
  localparam logic [1:0] LAMP_RED    = 2'd3;

  localparam logic [1:0] MODE_OFF          = 2'd0;
  localparam logic [1:0] MODE_INTERMITTENT = 2'd1;
  localparam logic [1:0] MODE_CONSTANT     = 2'd2;

  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [BYTE_W-1:0] CMD_GREEN    = 8'h47;  // 'G'
  localparam logic [BYTE_W-1:0] CMD_YELLOW   = 8'h59;  // 'Y'
  localparam logic [BYTE_W-1:0] CMD_RED      = 8'h52;  // 'R'
  localparam logic [BYTE_W-1:0] CMD_FIRE     = 8'h46;  // 'F'
  localparam logic [BYTE_W-1:0] CMD_STOP     = 8'h53;  // 'S'
  localparam logic [BYTE_W-1:0] CMD_HEART    = 8'h48;  // 'H'
  localparam logic [BYTE_W-1:0] MSG_HEART    = 8'h68;  // 'h'
  localparam logic [BYTE_W-1:0] MSG_FLAME    = 8'h46;  // 'F'
  localparam logic [BYTE_W-1:0] MSG_CLEARED  = 8'h66;  // 'f'

endpackage

`default_nettype wire

// ----- hw/rtl/alarm_annunciator_controller.sv -----
// Alarm annunciator controller.
// Input stream: each word is either a command byte (in_tuser = 0) or a
// one-millisecond tick (in_tuser = 1) that carries the raw flame pin level.
// Output stream: exactly one word per input word, showing the lamps, the
// buzzer pin and an optional reply byte ('h', 'F' or 'f') after that word.
// Each word is processed by the logic in front of the output register and
// appears on out_tvalid in the next cycle. One word is
// taken per cycle; the output register is the only stage, so the input is
// ready whenever that register is empty or being drained in the same cycle.
// When the receiver stalls, the result holds and the input stalls with it.
// The APB port sets the toggle period, poll period and watchdog limit at
// byte addresses 0, 4 and 8; write it only while no word is in flight.
// Reset (synchronous, active low) lights green, silences the buzzer, clears
// all timers and the flame state, and loads the default periods 500, 200
// and 15000 ticks.
`default_nettype none

module alarm_annunciator_controller
  import aac_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  // [7:0] cmd_byte, [8] flame_pin, rest zero
  input  wire [IN_TDATA_W-1:0]   in_tdata,
  // [0] kind
  input  wire                    in_tuser,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  // [0] lamp_green, [1] lamp_yellow, [2] lamp_red, [3] buzzer_pin,
  // [4] send_valid, [12:5] send_byte, rest zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  wire                    cfg_psel,
  input  wire                    cfg_penable,
  input  wire                    cfg_pwrite,
  input  wire [ADDR_W-1:0]       cfg_paddr,
  input  wire [DATA_W-1:0]       cfg_pwdata,
  output logic [DATA_W-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  logic [PER_W-1:0]  toggle_period_r;
  logic [PER_W-1:0]  poll_period_r;
  logic [WDOG_W-1:0] watchdog_limit_r;

  logic [1:0]        lamp_select_r, lamp_select_nxt;
  logic [1:0]        buzz_mode_r, buzz_mode_nxt;
  logic              buzz_on_r, buzz_on_nxt;
  logic [PER_W-1:0]  toggle_elapsed_r, toggle_elapsed_nxt;
  logic [PER_W-1:0]  poll_elapsed_r, poll_elapsed_nxt;
  logic              flame_seen_r, flame_seen_nxt;
  logic [WDOG_W-1:0] idle_elapsed_r, idle_elapsed_nxt;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic              in_fire;
  logic              cfg_write;
  logic [1:0]        cfg_index;
  logic [BYTE_W-1:0] cmd_byte;
  logic              flame_now;
  logic [PER_W-1:0]  poll_inc;
  logic [PER_W-1:0]  toggle_inc;
  logic [WDOG_W-1:0] idle_inc;
  logic              send_valid;
  logic [BYTE_W-1:0] send_byte;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign cmd_byte  = in_tdata[BYTE_W-1:0];
  assign flame_now = !in_tdata[BYTE_W];

  assign poll_inc   = (poll_elapsed_r == PER_MAX) ? poll_elapsed_r : poll_elapsed_r + 1'b1;
  assign toggle_inc = (toggle_elapsed_r == PER_MAX) ? toggle_elapsed_r
                                                    : toggle_elapsed_r + 1'b1;
  assign idle_inc   = (idle_elapsed_r == WDOG_MAX) ? idle_elapsed_r : idle_elapsed_r + 1'b1;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_index  = cfg_paddr[3:2];
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_index)
      REG_TOGGLE_PERIOD:  cfg_prdata = {{(DATA_W-PER_W){1'b0}}, toggle_period_r};
      REG_POLL_PERIOD:    cfg_prdata = {{(DATA_W-PER_W){1'b0}}, poll_period_r};
      REG_WATCHDOG_LIMIT: cfg_prdata = {{(DATA_W-WDOG_W){1'b0}}, watchdog_limit_r};
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      toggle_period_r  <= TOGGLE_PERIOD_RST;
      poll_period_r    <= POLL_PERIOD_RST;
      watchdog_limit_r <= WATCHDOG_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TOGGLE_PERIOD:  toggle_period_r  <= cfg_pwdata[PER_W-1:0];
        REG_POLL_PERIOD:    poll_period_r    <= cfg_pwdata[PER_W-1:0];
        REG_WATCHDOG_LIMIT: watchdog_limit_r <= cfg_pwdata[WDOG_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state for one word.
  always_comb begin
    lamp_select_nxt    = lamp_select_r;
    buzz_mode_nxt      = buzz_mode_r;
    buzz_on_nxt        = buzz_on_r;
    toggle_elapsed_nxt = toggle_elapsed_r;
    poll_elapsed_nxt   = poll_elapsed_r;
    flame_seen_nxt     = flame_seen_r;
    idle_elapsed_nxt   = idle_elapsed_r;
    send_valid         = 1'b0;
    send_byte          = '0;

    if (in_tuser == KIND_CMD) begin
      idle_elapsed_nxt = '0;
      case (cmd_byte)
        CMD_GREEN: begin
          lamp_select_nxt = LAMP_GREEN;
          buzz_mode_nxt   = MODE_OFF;
          buzz_on_nxt     = 1'b0;
        end
        CMD_YELLOW: begin
          lamp_select_nxt = LAMP_YELLOW;
          buzz_mode_nxt   = MODE_OFF;
          buzz_on_nxt     = 1'b0;
        end
        CMD_RED: begin
          lamp_select_nxt    = LAMP_RED;
          buzz_mode_nxt      = MODE_INTERMITTENT;
          buzz_on_nxt        = 1'b0;
          toggle_elapsed_nxt = '0;
        end
        // Constant mode leaves the buzzer level alone until the next tick.
        CMD_FIRE: begin
          lamp_select_nxt = LAMP_RED;
          buzz_mode_nxt   = MODE_CONSTANT;
        end
        CMD_STOP: begin
          lamp_select_nxt = LAMP_OFF;
          buzz_mode_nxt   = MODE_OFF;
          buzz_on_nxt     = 1'b0;
        end
        CMD_HEART: begin
          send_valid = 1'b1;
          send_byte  = MSG_HEART;
        end
        default: ;
      endcase
    end else begin
      poll_elapsed_nxt = poll_inc;
      if (poll_inc >= poll_period_r) begin
        poll_elapsed_nxt = '0;
        if (flame_now != flame_seen_r) begin
          send_valid     = 1'b1;
          send_byte      = flame_now ? MSG_FLAME : MSG_CLEARED;
          flame_seen_nxt = flame_now;
        end
      end

      case (buzz_mode_r)
        MODE_CONSTANT: buzz_on_nxt = 1'b1;
        MODE_INTERMITTENT: begin
          toggle_elapsed_nxt = toggle_inc;
          if (toggle_inc >= toggle_period_r) begin
            toggle_elapsed_nxt = '0;
            buzz_on_nxt        = !buzz_on_r;
          end
        end
        default: buzz_on_nxt = 1'b0;
      endcase

      idle_elapsed_nxt = idle_inc;
      if (idle_inc > watchdog_limit_r) begin
        lamp_select_nxt  = LAMP_OFF;
        buzz_mode_nxt    = MODE_OFF;
        buzz_on_nxt      = 1'b0;
        idle_elapsed_nxt = '0;
      end
    end

    out_data_nxt = {{(OUT_TDATA_W-13){1'b0}}, send_byte, send_valid, !buzz_on_nxt,
                    lamp_select_nxt == LAMP_RED, lamp_select_nxt == LAMP_YELLOW,
                    lamp_select_nxt == LAMP_GREEN};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lamp_select_r    <= LAMP_GREEN;
      buzz_mode_r      <= MODE_OFF;
      buzz_on_r        <= 1'b0;
      toggle_elapsed_r <= '0;
      poll_elapsed_r   <= '0;
      flame_seen_r     <= 1'b0;
      idle_elapsed_r   <= '0;
    end else if (in_fire) begin
      lamp_select_r    <= lamp_select_nxt;
      buzz_mode_r      <= buzz_mode_nxt;
      buzz_on_r        <= buzz_on_nxt;
      toggle_elapsed_r <= toggle_elapsed_nxt;
      poll_elapsed_r   <= poll_elapsed_nxt;
      flame_seen_r     <= flame_seen_nxt;
      idle_elapsed_r   <= idle_elapsed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // At most one lamp is lit in any result.
  a_one_lamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $countones(out_tdata[2:0]) <= 1)
    else $error("more than one lamp lit");

  // No reply byte is carried without its valid flag.
  a_send_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[4]) |-> (out_tdata[12:5] == '0))
    else $error("send byte set without send valid");

  // Any command clears the watchdog timer.
  a_cmd_clears_wdog: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == KIND_CMD) |=> (idle_elapsed_r == '0))
    else $error("command did not clear the watchdog");

  // The unused buzzer mode code is never entered.
  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    buzz_mode_r != 2'd3)
    else $error("illegal buzzer mode");

endmodule

`default_nettype wire
